>>> rtl/cdnp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnp_pkg: shared types and constants
// Widths, request codes, per-slot reference codes and the beat carried
// down the slot chain.
// ----------------------------------------------------------------------------
package cdnp_pkg;

  localparam int GRID_BITS  = 12;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int COORD_W    = GRID_BITS + FRAC_BITS;
  localparam int REF_W      = FRAC_BITS + 1;
  localparam int SQ_W       = 2 * FRAC_BITS + 1;
  localparam int DIST_W     = 2 * FRAC_BITS + 2;
  localparam int OUT_DIST_W = 33;
  localparam int MASK_W     = 8;
  localparam int CNT_W      = 5;

  // tan(22.5 deg)/2 in Q48, rounded to FRAC_BITS
  localparam logic [63:0] DIST_22_5_Q48 = 64'h3504_F333_F9DE;
  localparam logic [63:0] DIST_ROUND =
    (DIST_22_5_Q48 + (64'd1 << (47 - FRAC_BITS))) >> (48 - FRAC_BITS);
  localparam logic [REF_W-1:0] REF_HALF = REF_W'(1) << (FRAC_BITS - 1);
  localparam logic [REF_W-1:0] REF_D    = DIST_ROUND[REF_W-1:0];

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_MERGE  = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic {
    CFG_CELL_COLUMN = 1'b0,
    CFG_CELL_ROW    = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    REF_ZERO = 3'd0,
    REF_LOW  = 3'd1,
    REF_MID  = 3'd2,
    REF_HIGH = 3'd3,
    REF_ONE  = 3'd4
  } ref_code_t;

  localparam ref_code_t REF_X_CODE [NUM_SLOTS] = '{
    REF_MID, REF_HIGH, REF_ONE, REF_ONE, REF_ONE, REF_ONE, REF_ONE, REF_HIGH,
    REF_MID, REF_LOW, REF_ZERO, REF_ZERO, REF_ZERO, REF_ZERO, REF_ZERO, REF_LOW
  };
  localparam ref_code_t REF_Y_CODE [NUM_SLOTS] = '{
    REF_ONE, REF_ONE, REF_ONE, REF_HIGH, REF_MID, REF_LOW, REF_ZERO, REF_ZERO,
    REF_ZERO, REF_ZERO, REF_ZERO, REF_LOW, REF_MID, REF_HIGH, REF_ONE, REF_ONE
  };

  function automatic logic [REF_W-1:0] ref_value(input ref_code_t code);
    logic [REF_W-1:0] v;
    v = '0;
    case (code)
      REF_ZERO: v = '0;
      REF_LOW:  v = REF_HALF - REF_D;
      REF_MID:  v = REF_HALF;
      REF_HIGH: v = REF_HALF + REF_D;
      default:  v = REF_W'(1) << FRAC_BITS;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic                 vld;
    req_t                 req;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_W-1:0]     improved;
    logic                 rd_valid;
    logic [COORD_W-1:0]   rd_x;
    logic [COORD_W-1:0]   rd_y;
    logic [DIST_W-1:0]    rd_dist;
    logic                 ooc;
    logic [MASK_W-1:0]    src_mask;
  } pkt_t;

endpackage

>>> rtl/cdnp_slot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnp_slot_cell: one direction slot of the chain
// Stage A squares the axis offsets against the slot reference, stage B
// compares, updates the slot and fills read data; the beat moves on.
// ----------------------------------------------------------------------------
module cdnp_slot_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [cdnp_pkg::SLOT_W-1:0] slot_id,
  input  logic [cdnp_pkg::REF_W-1:0]  ref_x,
  input  logic [cdnp_pkg::REF_W-1:0]  ref_y,
  input  cdnp_pkg::pkt_t              pkt_i,
  output cdnp_pkg::pkt_t              pkt_o
);
  import cdnp_pkg::*;

  logic [REF_W-1:0]   ox, oy, dx, dy;
  logic [SQ_W-1:0]    sqx_nxt, sqy_nxt, sqx_r, sqy_r;
  pkt_t               pa_r, pb_r, pb_nxt;
  logic               present_r, present_nxt;
  logic [DIST_W-1:0]  sd_r, sd_nxt, cand_dist;
  logic [COORD_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic               offer, better, take, hit;

  // stage A
  always_comb begin
    ox = {1'b0, pkt_i.x[FRAC_BITS-1:0]};
    oy = {1'b0, pkt_i.y[FRAC_BITS-1:0]};
    dx = (ox >= ref_x) ? ox - ref_x : ref_x - ox;
    dy = (oy >= ref_y) ? oy - ref_y : ref_y - oy;
    sqx_nxt = SQ_W'(dx) * SQ_W'(dx);
    sqy_nxt = SQ_W'(dy) * SQ_W'(dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_r <= '0;
    end else begin
      pa_r <= pkt_i;
    end
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
  end

  // stage B
  always_comb begin
    cand_dist = DIST_W'(sqx_r) + DIST_W'(sqy_r);
    hit       = (pa_r.slot == slot_id);
    offer     = pa_r.vld && !pa_r.ooc &&
                (pa_r.req == REQ_INSERT || (pa_r.req == REQ_MERGE && hit));
    better    = (cand_dist < sd_r) ||
                (cand_dist == sd_r &&
                 (pa_r.x < sx_r || (pa_r.x == sx_r && pa_r.y < sy_r)));
    take      = offer && (!present_r || better);

    present_nxt = present_r;
    sd_nxt      = sd_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    pb_nxt      = pa_r;

    if (take) begin
      present_nxt     = 1'b1;
      sd_nxt          = cand_dist;
      sx_nxt          = pa_r.x;
      sy_nxt          = pa_r.y;
      pb_nxt.improved = pa_r.improved + CNT_W'(1);
    end
    if (pa_r.vld && pa_r.req == REQ_CLEAR) begin
      present_nxt = 1'b0;
    end
    if (pa_r.vld && pa_r.req == REQ_READ && hit && present_r) begin
      pb_nxt.rd_valid = 1'b1;
      pb_nxt.rd_x     = sx_r;
      pb_nxt.rd_y     = sy_r;
      pb_nxt.rd_dist  = sd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= 1'b0;
      pb_r      <= '0;
    end else begin
      present_r <= present_nxt;
      pb_r      <= pb_nxt;
    end
    sd_r <= sd_nxt;
    sx_r <= sx_nxt;
    sy_r <= sy_nxt;
  end

  assign pkt_o = pb_r;

endmodule

>>> rtl/cell_directional_nearest_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_directional_nearest_points: directional extreme points of one cell
// Sixteen slot cells in a chain; each request beat walks the chain and
// comes out as exactly one result beat.
// ----------------------------------------------------------------------------
// Pipeline: entry register, two stages in each of the 16 slot cells, then the
//   output register that raises out_valid.
// Throughput: one request per cycle; busy stays low, the chain is fully pipelined.
// Reset: synchronous, active low; empties all slots, clears the source mask and
//   the cell registers, and drops beats in flight.
// Results cannot be stalled; out_valid marks each one for a single cycle.
module cell_directional_nearest_points (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_req_type,
  input  logic [cdnp_pkg::COORD_W-1:0]    in_x_pos,
  input  logic [cdnp_pkg::COORD_W-1:0]    in_y_pos,
  input  logic [cdnp_pkg::SLOT_W-1:0]     in_slot_index,
  input  logic [cdnp_pkg::MASK_W-1:0]     in_source_bits,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [cdnp_pkg::GRID_BITS-1:0]  cfg_data,
  output logic                            out_valid,
  output logic                            out_slot_valid,
  output logic [cdnp_pkg::COORD_W-1:0]    out_point_x,
  output logic [cdnp_pkg::COORD_W-1:0]    out_point_y,
  output logic [cdnp_pkg::OUT_DIST_W-1:0] out_squared_distance,
  output logic [cdnp_pkg::MASK_W-1:0]     out_source_mask,
  output logic [cdnp_pkg::CNT_W-1:0]      out_improved_count,
  output logic                            out_out_of_cell
);
  import cdnp_pkg::*;

  localparam logic [DIST_W-1:0] DIST_SAT = DIST_W'({OUT_DIST_W{1'b1}});

  logic [GRID_BITS-1:0] col_r, row_r;
  logic [MASK_W-1:0]    src_r, src_nxt;
  logic                 acc, in_cell, offer_req, ooc;
  req_t                 req;
  pkt_t                 pkt0_r, pkt0_nxt;
  pkt_t                 chain [NUM_SLOTS+1];
  pkt_t                 last;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CELL_COLUMN: col_r <= cfg_data;
        CFG_CELL_ROW:    row_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_comb begin
    acc       = start && !busy;
    req       = req_t'(in_req_type);
    in_cell   = (in_x_pos[COORD_W-1:FRAC_BITS] == col_r) &&
                (in_y_pos[COORD_W-1:FRAC_BITS] == row_r);
    offer_req = (req == REQ_INSERT) || (req == REQ_MERGE);
    ooc       = offer_req && !in_cell;

    src_nxt = src_r;
    case (req)
      REQ_MERGE: if (in_cell) src_nxt = src_r | in_source_bits;
      REQ_CLEAR: src_nxt = '0;
      default:   ;
    endcase

    pkt0_nxt          = '0;
    pkt0_nxt.vld      = acc;
    pkt0_nxt.req      = req;
    pkt0_nxt.x        = in_x_pos;
    pkt0_nxt.y        = in_y_pos;
    pkt0_nxt.slot     = in_slot_index;
    pkt0_nxt.ooc      = ooc;
    pkt0_nxt.src_mask = src_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r  <= '0;
      pkt0_r <= '0;
    end else begin
      if (acc) begin
        src_r <= src_nxt;
      end
      pkt0_r <= pkt0_nxt;
    end
  end

  assign chain[0] = pkt0_r;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    cdnp_slot_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .slot_id (SLOT_W'(i)),
      .ref_x   (ref_value(REF_X_CODE[i])),
      .ref_y   (ref_value(REF_Y_CODE[i])),
      .pkt_i   (chain[i]),
      .pkt_o   (chain[i+1])
    );
  end

  assign last = chain[NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= last.vld;
    end
    out_slot_valid       <= last.rd_valid;
    out_point_x          <= last.rd_x;
    out_point_y          <= last.rd_y;
    out_squared_distance <= (last.rd_dist > DIST_SAT) ? {OUT_DIST_W{1'b1}}
                                                      : last.rd_dist[OUT_DIST_W-1:0];
    out_source_mask      <= last.src_mask;
    out_improved_count   <= last.improved;
    out_out_of_cell      <= last.ooc;
  end

endmodule

>>> rtl/cdnp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdnp_checker: port-level checks on result beats
// Consistency of result fields between request kinds, and reset behavior.
// ----------------------------------------------------------------------------
module cdnp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_slot_valid,
  input logic [cdnp_pkg::COORD_W-1:0]    out_point_x,
  input logic [cdnp_pkg::COORD_W-1:0]    out_point_y,
  input logic [cdnp_pkg::OUT_DIST_W-1:0] out_squared_distance,
  input logic [cdnp_pkg::CNT_W-1:0]      out_improved_count,
  input logic                            out_out_of_cell
);
  import cdnp_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_improved_count <= CNT_W'(NUM_SLOTS))
    else $error("improved count above slot count");

  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_slot_valid |->
      out_point_x == '0 && out_point_y == '0 && out_squared_distance == '0)
    else $error("read data without a valid slot");

  a_ooc_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_cell |-> out_improved_count == '0 && !out_slot_valid)
    else $error("outside point changed a slot");

  a_read_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_slot_valid |-> out_improved_count == '0 && !out_out_of_cell)
    else $error("read beat carries update status");

endmodule

bind cell_directional_nearest_points cdnp_checker u_cdnp_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_slot_valid       (out_slot_valid),
  .out_point_x          (out_point_x),
  .out_point_y          (out_point_y),
  .out_squared_distance (out_squared_distance),
  .out_improved_count   (out_improved_count),
  .out_out_of_cell      (out_out_of_cell)
);
